// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by weighted_random_select_tree.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define WRST_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

`define WRST_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`else

`define WRST_ASSERT(lbl, clk, rst_n, prop)

`define WRST_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ----- hw/rtl/wrst_pkg.sv -----
// types and constants of the weighted random select tree
`default_nettype none

package wrst_pkg;

	localparam int ENTRIES_DEF     = 256;
	localparam int WEIGHT_BITS_DEF = 32;

	localparam int INDEX_W   = 8;
	localparam int IN_WGT_W  = 32;
	localparam int DRAW_W    = 32;
	localparam int TOTAL_W   = 40;
	localparam int S_TDATA_W = INDEX_W + IN_WGT_W + DRAW_W;
	localparam int M_TDATA_W = INDEX_W + TOTAL_W;

	localparam logic OP_SET  = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SET_RD,
		ST_SET_WR,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_POS,
		ST_DSC_RD,
		ST_DSC_W,
		ST_DSC_L,
		ST_DONE
	} wrst_state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/weighted_random_select_tree.sv -----
// weighted random select over a heap-shaped sum tree held in two memories
// set: ST_SET_RD and ST_SET_WR per tree level from the entry up to the root, then ST_DONE
// draw: scaling multiply, then DSC_RD, DSC_W, DSC_L per level; an own-weight hit ends at DSC_W
// one operation at a time; the per-level memory steps of the tree walk set the rate
// the result word waits in an output register while the next word is taken
// after reset the memories are swept to zero with s_tready low
`default_nettype none

`include "assert_macros.svh"

module weighted_random_select_tree
	import wrst_pkg::*;
#(
	parameter int ENTRIES     = ENTRIES_DEF,
	parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // entry_index, new_weight, draw
	input  wire logic                 s_tuser,  // operation
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [M_TDATA_W-1:0]      m_tdata,  // chosen_index, total_weight
	output logic                      m_tuser   // found
);

	localparam int IDXW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SUM_BITS = WEIGHT_BITS + IDXW;
	localparam int CW       = IDXW + 2;
	localparam int NW       = (IDXW > INDEX_W) ? IDXW : INDEX_W;
	localparam int TW       = (SUM_BITS > TOTAL_W) ? SUM_BITS : TOTAL_W;

	wrst_state_t state_q, state_d;

	logic [WEIGHT_BITS-1:0] wmem [ENTRIES];
	logic [SUM_BITS-1:0]    smem [ENTRIES];

	logic [WEIGHT_BITS-1:0] rd_w_q;
	logic [SUM_BITS-1:0]    rd_sa_q, rd_sb_q;

	logic [IDXW-1:0]     node_q, clr_q;
	logic                found_q;
	logic [SUM_BITS-1:0] pos_q, total_q;
	logic [DRAW_W-1:0]   draw_q;
	logic [31:0]         prod_lo_q;
	logic [63:0]         prod_q;

	logic                   w_we, s_we;
	logic [IDXW-1:0]        w_wa, s_wa;
	logic [WEIGHT_BITS-1:0] w_wd;
	logic [SUM_BITS-1:0]    s_wd;

	logic [INDEX_W-1:0]  in_index;
	logic [IN_WGT_W-1:0] in_weight;
	logic [DRAW_W-1:0]   in_draw;
	logic                accept, in_range, out_free;

	logic [CW-1:0]       left_c, right_c;
	logic                left_ok, right_ok, is_root;
	logic [IDXW-1:0]     node_m1, parent;
	logic [SUM_BITS-1:0] own_w, left_s, right_s, node_sum;
	logic [63:0]         tot_pad, prod_c;
	logic [31:0]         mul_b;
	logic [NW-1:0]       node_ext;
	logic [TW-1:0]       total_ext;
	logic                out_total_zero;

	assign in_index  = s_tdata[INDEX_W-1:0];
	assign in_weight = s_tdata[INDEX_W +: IN_WGT_W];
	assign in_draw   = s_tdata[INDEX_W + IN_WGT_W +: DRAW_W];

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign in_range = 32'(in_index) < 32'(ENTRIES);
	assign out_free = !m_tvalid || m_tready;

	assign left_c   = {1'b0, node_q, 1'b1};
	assign right_c  = left_c + CW'(1);
	assign left_ok  = 32'(left_c) < 32'(ENTRIES);
	assign right_ok = 32'(right_c) < 32'(ENTRIES);
	assign is_root  = (node_q == '0);
	assign node_m1  = node_q - IDXW'(1);
	assign parent   = node_m1 >> 1;

	assign own_w    = SUM_BITS'(rd_w_q);
	assign left_s   = left_ok ? rd_sa_q : '0;
	assign right_s  = right_ok ? rd_sb_q : '0;
	assign node_sum = own_w + left_s + right_s;

	assign tot_pad = 64'(total_q);
	assign mul_b   = (state_q == ST_MUL_LO) ? tot_pad[31:0] : tot_pad[63:32];
	assign prod_c  = 64'(draw_q) * 64'(mul_b);

	assign node_ext  = NW'(node_q);
	assign total_ext = TW'(total_q);

	assign out_total_zero = (m_tdata[M_TDATA_W-1:INDEX_W] == '0) && (SUM_BITS <= TOTAL_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		w_we    = 1'b0;
		w_wa    = node_q;
		w_wd    = WEIGHT_BITS'(in_weight);
		s_we    = 1'b0;
		s_wa    = node_q;
		s_wd    = node_sum;
		case (state_q)
			ST_CLEAR: begin
				w_we = 1'b1;
				w_wa = clr_q;
				w_wd = '0;
				s_we = 1'b1;
				s_wa = clr_q;
				s_wd = '0;
				if (clr_q == IDXW'(ENTRIES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				w_wa = IDXW'(in_index);
				if (accept) begin
					if (s_tuser == OP_SET) begin
						w_we    = in_range;
						state_d = in_range ? ST_SET_RD : ST_DONE;
					end else begin
						state_d = (total_q == '0) ? ST_DONE : ST_MUL_LO;
					end
				end
			end
			ST_SET_RD: state_d = ST_SET_WR;
			ST_SET_WR: begin
				s_we    = 1'b1;
				state_d = is_root ? ST_DONE : ST_SET_RD;
			end
			ST_MUL_LO: state_d = ST_MUL_HI;
			ST_MUL_HI: state_d = ST_POS;
			ST_POS:    state_d = ST_DSC_RD;
			ST_DSC_RD: state_d = ST_DSC_W;
			ST_DSC_W: begin
				state_d = (pos_q < own_w) ? ST_DONE : ST_DSC_L;
			end
			ST_DSC_L: begin
				if (left_ok && pos_q < rd_sa_q) begin
					state_d = ST_DSC_RD;
				end else begin
					state_d = right_ok ? ST_DSC_RD : ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk) begin
		if (w_we) begin
			wmem[w_wa] <= w_wd;
		end
		rd_w_q <= wmem[node_q];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			smem[s_wa] <= s_wd;
		end
		rd_sa_q <= smem[left_c[IDXW-1:0]];
		rd_sb_q <= smem[right_c[IDXW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			total_q <= '0;
			found_q <= 1'b0;
			node_q  <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + IDXW'(1);
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser == OP_SET) begin
							found_q <= 1'b0;
							node_q  <= IDXW'(in_index);
						end else begin
							found_q <= (total_q != '0);
							node_q  <= '0;
						end
					end
				end
				ST_SET_WR: begin
					if (is_root) begin
						total_q <= node_sum;
					end else begin
						node_q <= parent;
					end
				end
				ST_DSC_L: begin
					if (left_ok && pos_q < rd_sa_q) begin
						node_q <= left_c[IDXW-1:0];
					end else if (right_ok) begin
						node_q <= right_c[IDXW-1:0];
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: draw_q <= in_draw;
			ST_MUL_LO: prod_lo_q <= prod_c[63:32];
			ST_MUL_HI: prod_q <= prod_c;
			ST_POS: pos_q <= SUM_BITS'(prod_q + 64'(prod_lo_q));
			ST_DSC_W: pos_q <= pos_q - own_w;
			ST_DSC_L: begin
				if (!(left_ok && pos_q < rd_sa_q)) begin
					pos_q <= pos_q - left_s;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			m_tdata <= {total_ext[TOTAL_W-1:0], found_q ? node_ext[INDEX_W-1:0] : INDEX_W'(0)};
			m_tuser <= found_q;
		end
	end

	`WRST_ASSERT(a_clear_total_zero, clk, arst_n, (state_q == ST_CLEAR) |-> (total_q == '0))
	`WRST_NEVER(a_found_on_empty, clk, arst_n, m_tvalid && m_tuser && out_total_zero)
	`WRST_NEVER(a_dual_write, clk, arst_n, w_we && s_we && (state_q != ST_CLEAR))
	`WRST_ASSERT(a_root_ends_set, clk, arst_n, (state_q == ST_SET_WR && is_root) |=> (state_q == ST_DONE))
	`WRST_ASSERT(a_node_in_range, clk, arst_n, (state_q == ST_DONE && found_q) |-> (32'(node_q) < 32'(ENTRIES)))

endmodule

`default_nettype wire
